FILE: rtl/core/cisl_pkg.sv
// Shared types and constants of the compacting identifier slot list.
`timescale 1ns / 1ps
`default_nettype none

package cisl_pkg;

   localparam int IdentWidth       = 16;
   localparam int StatusWidth      = 2;
   localparam int OccupancyWidth   = 5;
   localparam int DEFAULT_CAPACITY = 16;

   localparam logic [IdentWidth-1:0] EMPTY_ID = '1;

   typedef enum logic {
      OP_ADD    = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic                  valid;
      op_type                op;
      logic [IdentWidth-1:0] ident;
   } cmd_type;

   // Contents of one slot as it moves between neighboring cells.
   typedef struct packed {
      logic                  occupied;
      logic [IdentWidth-1:0] ident;
   } slot_type;

endpackage : cisl_pkg

`default_nettype wire

FILE: rtl/core/cisl_cell.sv
// One slot cell of the list: match, hit chain, neighbor shift and append.
`timescale 1ns / 1ps
`default_nettype none

module cisl_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cisl_pkg::cmd_type cmd,
   input  wire logic              left_occupied,
   input  wire logic              hit_in,
   input  wire cisl_pkg::slot_type right_slot,
   output logic                   hit_out,
   output cisl_pkg::slot_type     slot
);
   import cisl_pkg::*;

   slot_type slot_ff;
   slot_type slot_in;
   logic     match;

   assign match   = (cmd.op == OP_REMOVE) && slot_ff.occupied && (slot_ff.ident == cmd.ident);
   assign hit_out = hit_in | match;
   assign slot    = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      if (cmd.valid) begin
         if (cmd.op == OP_REMOVE) begin
            // This cell or a lower one matched: take the neighbor's slot.
            if (hit_out) begin
               slot_in = right_slot;
            end
         end else if (left_occupied && !slot_ff.occupied) begin
            // First empty slot of the list takes the new identifier.
            slot_in.occupied = 1'b1;
            slot_in.ident    = cmd.ident;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '{occupied: 1'b0, ident: EMPTY_ID};
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule : cisl_cell

`default_nettype wire

FILE: rtl/core/compacting_id_slot_list.sv
// Top level of the compacting identifier slot list.
`timescale 1ns / 1ps
`default_nettype none

// Channel       Direction  Ports                              Handshake
// ------------  ---------  ---------------------------------  ------------------------------
// request       in         req_op, req_ident                  start high while busy is low
// response      out        rsp_status, rsp_occupancy          rsp_strobe, one cycle, no stall
//
// A request transaction is captured into a command register at the edge where it is
// accepted. At the next edge the row of cells updates and the response is registered, so
// the response passes the command register and then the response registers. A new
// transaction may be accepted in every cycle, and busy stays low. The cell row holds the
// slots; its hit chain from slot 0 upward sets the combinational depth of the update.
// Reset is synchronous and active high; it empties all slots and clears the count at once,
// so no clearing pass follows. The receiver cannot stall the response.
//
// Add writes the first empty slot, which is always the slot at the current count because
// the occupied slots stay packed at the low end. Remove finds the lowest occupied slot
// equal to the identifier; that cell and every cell above it take the contents of their
// upper neighbor in the same cycle, and the top cell becomes empty.

module compacting_id_slot_list #(
   parameter int CAPACITY = cisl_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_op,
   input  wire logic [cisl_pkg::IdentWidth-1:0]   req_ident,
   output logic                                   rsp_strobe,
   output logic [cisl_pkg::StatusWidth-1:0]       rsp_status,
   output logic [cisl_pkg::OccupancyWidth-1:0]    rsp_occupancy
);
   import cisl_pkg::*;

   localparam int CountWidth = $clog2(CAPACITY + 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(CAPACITY);

   // Command register between the request port and the cell row.
   cmd_type cmd_ff;
   cmd_type cmd_in;

   // Number of occupied slots.
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;

   // Registered response.
   logic                       rsp_strobe_ff;
   logic                       rsp_strobe_in;
   status_type                 rsp_status_ff;
   status_type                 rsp_status_in;
   logic [OccupancyWidth-1:0]  rsp_occupancy_ff;
   logic [OccupancyWidth-1:0]  rsp_occupancy_in;

   // Links along the cell row.
   logic     hit_chain [CAPACITY+1];
   slot_type slots     [CAPACITY];
   logic     found;
   logic     full;
   logic [31:0] count_wide;

   assign busy = 1'b0;

   assign cmd_in.valid = start && !busy;
   assign cmd_in.op    = op_type'(req_op);
   assign cmd_in.ident = req_ident;

   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic     left_occupied;
      slot_type right_slot;

      if (i == 0) begin : g_first
         // Slot 0 has no lower neighbor; treat it as occupied so an empty list appends here.
         assign left_occupied = 1'b1;
      end else begin : g_inner
         assign left_occupied = slots[i-1].occupied;
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_slot = '{occupied: 1'b0, ident: EMPTY_ID};
      end else begin : g_upper
         assign right_slot = slots[i+1];
      end

      cisl_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd_ff),
         .left_occupied (left_occupied),
         .hit_in        (hit_chain[i]),
         .right_slot    (right_slot),
         .hit_out       (hit_chain[i+1]),
         .slot          (slots[i])
      );
   end

   assign found = hit_chain[CAPACITY];
   assign full  = (count_ff == CountFull);

   // Count update and response for the command held in the command register.
   always_comb begin
      count_in      = count_ff;
      rsp_strobe_in = cmd_ff.valid;
      rsp_status_in = ST_DONE;
      if (cmd_ff.valid) begin
         if (cmd_ff.op == OP_REMOVE) begin
            if (found) begin
               count_in = count_ff - CountWidth'(1);
            end else begin
               rsp_status_in = ST_NOT_FOUND;
            end
         end else begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               count_in = count_ff + CountWidth'(1);
            end
         end
      end
      // The occupancy field carries the low bits of the count only.
      count_wide       = 32'(count_in);
      rsp_occupancy_in = count_wide[OccupancyWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff.valid     <= 1'b0;
         cmd_ff.op        <= OP_ADD;
         cmd_ff.ident     <= '0;
         count_ff         <= '0;
         rsp_strobe_ff    <= 1'b0;
         rsp_status_ff    <= ST_DONE;
         rsp_occupancy_ff <= '0;
      end else begin
         cmd_ff           <= cmd_in;
         count_ff         <= count_in;
         rsp_strobe_ff    <= rsp_strobe_in;
         rsp_status_ff    <= rsp_status_in;
         rsp_occupancy_ff <= rsp_occupancy_in;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

   // The occupied slots form a packed prefix, so slot 0 is occupied exactly when the list
   // is not empty.
   a_slot0_matches_count : assert property (@(posedge clock) disable iff (reset)
      slots[0].occupied == (count_ff != '0))
      else $error("slot 0 occupancy disagrees with the count");

   // The count never exceeds the number of slots.
   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountFull)
      else $error("count exceeds capacity");

   // A successful remove lowers the count by one.
   a_remove_decrements : assert property (@(posedge clock) disable iff (reset)
      (cmd_ff.valid && cmd_ff.op == OP_REMOVE && found)
      |=> count_ff == $past(count_ff) - CountWidth'(1))
      else $error("remove hit did not decrement the count");

   // A refused transaction leaves the count unchanged.
   a_refused_keeps_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_FULL || rsp_status == ST_NOT_FOUND))
      |-> count_ff == $past(count_ff))
      else $error("refused transaction changed the count");

endmodule : compacting_id_slot_list

`default_nettype wire
